// ----- hw/rtl/rsms_pkg.sv -----
// Shared types and constants for the row statistics unit.
// Depends on nothing; every other file refers to it by scoped names.
package rsms_pkg;

	localparam int unsigned ELEM_W      = 16;
	localparam int unsigned LEN_W       = 13;
	localparam int unsigned SUM_W       = 29;
	localparam int unsigned SUMSQ_W     = 43;
	localparam int unsigned TOTAL_W     = 28;
	localparam int unsigned Q8_W        = 24;
	localparam int unsigned MAX_ROW_LEN = 4096;
	localparam int unsigned SQRT_STEPS  = 36;
	localparam int unsigned DIV_STEPS   = 36;
	localparam int unsigned STEP_W      = 6;

	// One closed row handed from the accumulator to the back end
	typedef struct packed {
		logic [LEN_W-1:0]          n;
		logic signed [SUM_W-1:0]   sum;
		logic [SUMSQ_W-1:0]        sumsq;
	} snap_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic mul_lo;
		logic mul_hi;
		logic diff;
		logic sqrt_step;
		logic div_step;
		logic std_init;
		logic out_load;
	} cmd_t;

	// Status back to the controller
	typedef struct packed {
		logic snap_valid;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/rsms_front.sv -----
// Element accumulator: running sum, sum of squares and count per row.
// Depends on rsms_pkg.
module rsms_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rsms_pkg::LEN_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [rsms_pkg::ELEM_W-1:0]    element_value,
	input  logic                                  take,
	output logic                                  snap_valid,
	output rsms_pkg::snap_t                       snap,
	output logic                                  row_close
);

	logic [rsms_pkg::LEN_W-1:0]          row_len_q;
	logic [rsms_pkg::LEN_W-1:0]          count_q;
	logic signed [rsms_pkg::SUM_W-1:0]   sum_q;
	logic [rsms_pkg::SUMSQ_W-1:0]        sumsq_q;
	logic                                snap_valid_q;
	rsms_pkg::snap_t                     snap_q;

	logic [rsms_pkg::LEN_W-1:0]          eff;
	logic [rsms_pkg::LEN_W-1:0]          count_nx;
	logic signed [2*rsms_pkg::ELEM_W-1:0] sq;
	logic signed [rsms_pkg::SUM_W-1:0]   sum_nx;
	logic [rsms_pkg::SUMSQ_W-1:0]        sumsq_nx;
	logic                                accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !snap_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		priority if (row_len_q == '0) begin
			eff = rsms_pkg::LEN_W'(1);
		end else if (row_len_q > rsms_pkg::LEN_W'(rsms_pkg::MAX_ROW_LEN)) begin
			eff = rsms_pkg::LEN_W'(rsms_pkg::MAX_ROW_LEN);
		end else begin
			eff = row_len_q;
		end
	end

	assign count_nx  = count_q + rsms_pkg::LEN_W'(1);
	assign sq        = element_value * element_value;
	assign sum_nx    = sum_q + rsms_pkg::SUM_W'(element_value);
	assign sumsq_nx  = sumsq_q + rsms_pkg::SUMSQ_W'(sq[2*rsms_pkg::ELEM_W-2:0]);
	assign row_close = accept && (count_nx >= eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q    <= rsms_pkg::LEN_W'(1000);
			count_q      <= '0;
			sum_q        <= '0;
			sumsq_q      <= '0;
			snap_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				row_len_q <= cfg_data;
			end
			if (take) begin
				snap_valid_q <= 1'b0;
			end
			if (accept) begin
				if (row_close) begin
					count_q      <= '0;
					sum_q        <= '0;
					sumsq_q      <= '0;
					snap_valid_q <= 1'b1;
				end else begin
					count_q <= count_nx;
					sum_q   <= sum_nx;
					sumsq_q <= sumsq_nx;
				end
			end
		end
	end

	// Payload snapshot of the closed row
	always_ff @(posedge clk) begin
		if (row_close) begin
			snap_q.n     <= count_nx;
			snap_q.sum   <= sum_nx;
			snap_q.sumsq <= sumsq_nx;
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap       = snap_q;

endmodule

// ----- hw/rtl/rsms_ctrl.sv -----
// Sequencer for the back end: multiply, difference, root and divides.
// Depends on rsms_pkg.
module rsms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  rsms_pkg::sts_t   sts,
	output rsms_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_LO, S_MUL_HI, S_DIFF, S_ROOT, S_STD_INIT, S_DIV_STD, S_OUT
	} state_t;

	state_t                        state_q;
	logic [rsms_pkg::STEP_W-1:0]   step_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.take      = sts.snap_valid;
			S_MUL_LO:   cmd.mul_lo    = 1'b1;
			S_MUL_HI:   cmd.mul_hi    = 1'b1;
			S_DIFF:     cmd.diff      = 1'b1;
			S_ROOT: begin
				cmd.sqrt_step = 1'b1;
				cmd.div_step  = 1'b1;
			end
			S_STD_INIT: cmd.std_init  = 1'b1;
			S_DIV_STD:  cmd.div_step  = 1'b1;
			S_OUT:      cmd.out_load  = sts.out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE:     if (sts.snap_valid) state_q <= S_MUL_LO;
				S_MUL_LO:   state_q <= S_MUL_HI;
				S_MUL_HI:   state_q <= S_DIFF;
				S_DIFF: begin
					step_q  <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					step_q <= step_q + rsms_pkg::STEP_W'(1);
					if (step_q == rsms_pkg::STEP_W'(rsms_pkg::SQRT_STEPS - 1)) begin
						state_q <= S_STD_INIT;
					end
				end
				S_STD_INIT: begin
					step_q  <= '0;
					state_q <= S_DIV_STD;
				end
				S_DIV_STD: begin
					step_q <= step_q + rsms_pkg::STEP_W'(1);
					if (step_q == rsms_pkg::STEP_W'(rsms_pkg::DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT:      if (sts.out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rsms_dp.sv -----
// Back-end datapath: variance numerator, bit-serial root, serial divider
// and the output register. Depends on rsms_pkg.
module rsms_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rsms_pkg::cmd_t                         cmd,
	input  rsms_pkg::snap_t                        snap,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic                                   out_free,
	output logic signed [rsms_pkg::TOTAL_W-1:0]    row_total,
	output logic signed [rsms_pkg::Q8_W-1:0]       mean_q8,
	output logic [rsms_pkg::Q8_W-1:0]              std_q8
);

	localparam int unsigned ABS_W  = 28;
	localparam int unsigned D_W    = 56;
	localparam int unsigned RAD_W  = 72;
	localparam int unsigned ROOT_W = 36;
	localparam int unsigned REM_W  = 38;
	localparam int unsigned DVD_W  = 36;
	localparam int unsigned LO_W   = 22;

	logic [rsms_pkg::LEN_W-1:0]          n_q;
	logic signed [rsms_pkg::SUM_W-1:0]   s_q;
	logic [ABS_W-1:0]                    sabs_q;
	logic                                neg_q;
	logic [rsms_pkg::SUMSQ_W-1:0]        qsum_q;
	logic [D_W-1:0]                      plo_q, phi_q, sq_q;
	logic [RAD_W-1:0]                    rad_q;
	logic [REM_W-1:0]                    rem_q;
	logic [ROOT_W-1:0]                   root_q;
	logic [DVD_W-1:0]                    dvd_q;
	logic [rsms_pkg::LEN_W-1:0]          rdr_q;
	logic [rsms_pkg::Q8_W-1:0]           mean_q;
	logic                                out_valid_q;
	logic signed [rsms_pkg::TOTAL_W-1:0] total_q;
	logic [rsms_pkg::Q8_W-1:0]           omean_q, ostd_q;

	logic [rsms_pkg::SUM_W-1:0]          s_abs;
	logic [D_W-1:0]                      d_val;
	logic [REM_W+1:0]                    rem_t;
	logic [REM_W+1:0]                    trial;
	logic [rsms_pkg::LEN_W:0]            rdr_t;
	logic                                qbit;

	assign s_abs = snap.sum[rsms_pkg::SUM_W-1] ? (-snap.sum) : snap.sum;
	assign d_val = plo_q + (phi_q << LO_W) - sq_q;

	// Root step: two radicand bits in, one root bit out
	assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	// Divide step: one quotient bit
	assign rdr_t = {rdr_q, dvd_q[DVD_W-1]};
	assign qbit  = rdr_t >= {1'b0, n_q};

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			n_q    <= snap.n;
			s_q    <= snap.sum;
			sabs_q <= s_abs[ABS_W-1:0];
			neg_q  <= snap.sum[rsms_pkg::SUM_W-1];
			qsum_q <= snap.sumsq;
		end
		if (cmd.mul_lo) begin
			plo_q <= D_W'(n_q * qsum_q[LO_W-1:0]);
			sq_q  <= D_W'(sabs_q * sabs_q);
		end
		if (cmd.mul_hi) begin
			phi_q <= D_W'(n_q * qsum_q[rsms_pkg::SUMSQ_W-1:LO_W]);
		end
		if (cmd.diff) begin
			rad_q  <= {d_val, 16'b0};
			rem_q  <= '0;
			root_q <= '0;
			dvd_q  <= {sabs_q, 8'b0};
			rdr_q  <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (rem_t >= trial) begin
				rem_q  <= REM_W'(rem_t - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_t);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rdr_q <= qbit ? rsms_pkg::LEN_W'(rdr_t - {1'b0, n_q})
			              : rdr_t[rsms_pkg::LEN_W-1:0];
		end
		if (cmd.std_init) begin
			// Mean quotient is final here; truncate toward zero by sign fix-up
			mean_q <= neg_q ? (-dvd_q[rsms_pkg::Q8_W-1:0]) : dvd_q[rsms_pkg::Q8_W-1:0];
			dvd_q  <= root_q;
			rdr_q  <= '0;
		end
		if (cmd.out_load) begin
			total_q <= s_q[rsms_pkg::TOTAL_W-1:0];
			omean_q <= mean_q;
			ostd_q  <= dvd_q[rsms_pkg::Q8_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign row_total = total_q;
	assign mean_q8   = omean_q;
	assign std_q8    = ostd_q;

endmodule

// ----- hw/rtl/row_sum_mean_std_unit.sv -----
// Row statistics unit: top level joining accumulator, controller and datapath.
// Depends on rsms_pkg, rsms_front, rsms_ctrl and rsms_dp.
//
// Usage:
//   Elements arrive on the in_valid/in_ready channel in row-major order, one
//   request per cycle while the accumulator is free. Each closed row yields one
//   request on out_valid/out_ready carrying the exact row total, the mean and
//   the population standard deviation, both in Q.8.
//   row_length is written through cfg_valid/cfg_data (cfg_ready is always high);
//   write it only while the unit is idle. Zero acts as one, values above 4096
//   saturate to 4096.
// Back-end sequence:
//   Once the closing element is accepted, the back end takes the snapshot,
//   runs the multiplies and the difference, then the bit-serial square root
//   (the mean divide runs alongside), the standard deviation divide and
//   finally the output load. The serial root and divider dominate this
//   sequence; the back end takes a new row only after finishing the last one.
//   The input pauses at every row end while the snapshot is handed over;
//   rows of 77 or more elements need no further wait, shorter rows stall the
//   input while a snapshot waits.
// Reset and stalls:
//   arst_n clears the counters, the accumulators and all valids, and sets
//   row_length to 1000. If the receiver stalls, the result holds in the output
//   register, the back end waits, and the input stops at the next row end.
module row_sum_mean_std_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rsms_pkg::LEN_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [rsms_pkg::ELEM_W-1:0]     element_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rsms_pkg::TOTAL_W-1:0]    row_total,
	output logic signed [rsms_pkg::Q8_W-1:0]       mean_q8,
	output logic [rsms_pkg::Q8_W-1:0]              std_q8
);

	rsms_pkg::cmd_t  cmd;
	rsms_pkg::sts_t  sts;
	rsms_pkg::snap_t snap;
	logic            snap_valid;
	logic            out_free;
	logic            row_close;

	// Accumulate elements and hold the closed row
	rsms_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element_value (element_value),
		.take          (cmd.take),
		.snap_valid    (snap_valid),
		.snap          (snap),
		.row_close     (row_close)
	);

	assign sts.snap_valid = snap_valid;
	assign sts.out_free   = out_free;

	// Sequence the back-end arithmetic
	rsms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	rsms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.snap      (snap),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_free  (out_free),
		.row_total (row_total),
		.mean_q8   (mean_q8),
		.std_q8    (std_q8)
	);

`ifndef ASSERT_OFF
	a_close_snaps: assert property (@(posedge clk) disable iff (!arst_n)
		row_close |=> snap_valid && !in_ready)
		else $error("closed row not held in snapshot");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> snap_valid)
		else $error("back end took an empty snapshot");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register overwritten");
	a_load_raises: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule
